// ===== rtl/pm_pkg.sv =====
package pm_pkg;

    localparam int MAX_TERMS   = 32;
    localparam int COEFF_WIDTH = 16;
    localparam int OUT_WIDTH   = 38;

    localparam int IDX_W  = $clog2(MAX_TERMS);
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int K_W    = $clog2(2 * MAX_TERMS - 1);
    localparam int PROD_W = 2 * COEFF_WIDTH;
    localparam int ACC_W  = PROD_W + IDX_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_FIRST  = 1'b0,
        OP_SECOND = 1'b1
    } opcode_t;

    // Command word passed from the front end to the compute engine.
    typedef struct packed {
        logic                           wr;
        logic                           is_b;
        logic [IDX_W-1:0]               addr;
        logic signed [COEFF_WIDTH-1:0]  coeff;
        logic                           start;
        logic [CNT_W-1:0]               len_a;
        logic [CNT_W-1:0]               len_b;
        logic                           err;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/pm_operand_if.sv =====
interface pm_operand_if;
    import pm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [COEFF_WIDTH-1:0] coeff;
    logic                          last;

    modport source (output valid, output opcode, output coeff, output last, input ready);
    modport sink   (input valid, input opcode, input coeff, input last, output ready);
endinterface

// ===== rtl/pm_product_if.sv =====
interface pm_product_if;
    import pm_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] product_coeff;
    logic                        error;
    logic                        last_of_run;

    modport source (output valid, output product_coeff, output error, output last_of_run,
                    input ready);
    modport sink   (input valid, input product_coeff, input error, input last_of_run,
                    output ready);
endinterface

// ===== rtl/pm_front.sv =====
module pm_front (
    input  logic          clk,
    input  logic          rst_n,
    pm_operand_if.sink    operand,
    output pm_pkg::cmd_t  cmd,
    output logic          push,
    input  logic          full
);
    import pm_pkg::*;

    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic             first_done_reg, first_done_next;
    logic             dropped_reg, dropped_next;
    logic             accept;
    logic             wr_a, wr_b;

    assign operand.ready = !full;
    assign accept        = operand.valid && !full;
    assign push          = accept;

    always_comb
    begin
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        first_done_next = first_done_reg;
        dropped_next    = dropped_reg;
        wr_a            = !first_done_reg && (cnt_a_reg < CNT_W'(MAX_TERMS));
        wr_b            = cnt_b_reg < CNT_W'(MAX_TERMS);

        cmd       = '0;
        cmd.coeff = operand.coeff;

        if (operand.opcode == OP_FIRST)
        begin
            cmd.wr   = wr_a;
            cmd.is_b = 1'b0;
            cmd.addr = IDX_W'(cnt_a_reg);
            if (accept)
            begin
                if (wr_a)
                    cnt_a_next = cnt_a_reg + CNT_W'(1);
                else
                    dropped_next = 1'b1;
                if (operand.last)
                    first_done_next = 1'b1;
            end
        end
        else
        begin
            cmd.wr    = wr_b;
            cmd.is_b  = 1'b1;
            cmd.addr  = IDX_W'(cnt_b_reg);
            cmd.start = operand.last;
            cmd.len_a = cnt_a_reg;
            cmd.len_b = cnt_b_reg + CNT_W'(wr_b);
            cmd.err   = dropped_reg || !wr_b || (cnt_a_reg == '0);
            if (accept)
            begin
                if (wr_b)
                    cnt_b_next = cnt_b_reg + CNT_W'(1);
                else
                    dropped_next = 1'b1;
                // run closes: clear the operand bookkeeping
                if (operand.last)
                begin
                    cnt_a_next      = '0;
                    cnt_b_next      = '0;
                    first_done_next = 1'b0;
                    dropped_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            first_done_reg <= 1'b0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            first_done_reg <= first_done_next;
            dropped_reg    <= dropped_next;
        end
    end

endmodule

// ===== rtl/pm_queue.sv =====
module pm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pm_pkg::cmd_t  cmd_in,
    output logic          full,
    input  logic          pop,
    output pm_pkg::cmd_t  cmd_out,
    output logic          empty
);
    import pm_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/pm_engine.sv =====
module pm_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  pm_pkg::cmd_t  cmd,
    input  logic          empty,
    output logic          pop,
    pm_product_if.source  product
);
    import pm_pkg::*;

    logic signed [COEFF_WIDTH-1:0] mem_a [MAX_TERMS];
    logic signed [COEFF_WIDTH-1:0] mem_b [MAX_TERMS];

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  la_reg, la_next;
    logic [CNT_W-1:0]  lb_reg, lb_next;
    logic              err_reg, err_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [K_W-1:0]    kmax_reg, kmax_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  iend_reg, iend_next;
    logic [IDX_W-1:0]  addr_b;

    logic signed [COEFF_WIDTH-1:0] rd_a_reg, rd_b_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic                          s1_valid_reg, s1_last_reg;
    logic                          s2_valid_reg, s2_last_reg;

    logic                          out_valid_reg, out_valid_next;
    logic signed [OUT_WIDTH-1:0]   out_coeff_reg, out_coeff_next;
    logic                          out_err_reg, out_err_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_free;

    logic [K_W-1:0] k_inc, la_k, lb_k;

    assign addr_b   = IDX_W'(k_reg - K_W'(i_reg));
    assign out_free = !out_valid_reg || product.ready;
    assign k_inc    = k_reg + K_W'(1);
    assign la_k     = K_W'(la_reg);
    assign lb_k     = K_W'(lb_reg);

    assign product.valid         = out_valid_reg;
    assign product.product_coeff = out_coeff_reg;
    assign product.error         = out_err_reg;
    assign product.last_of_run   = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        la_next        = la_reg;
        lb_next        = lb_reg;
        err_next       = err_reg;
        k_next         = k_reg;
        kmax_next      = kmax_reg;
        i_next         = i_reg;
        iend_next      = iend_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !product.ready;
        out_coeff_next = out_coeff_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;

        acc_next = acc_reg;
        if (s2_valid_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                pop = !empty;
                if (!empty && cmd.start)
                begin
                    la_next   = cmd.len_a;
                    lb_next   = cmd.len_b;
                    err_next  = cmd.err;
                    k_next    = '0;
                    i_next    = '0;
                    iend_next = '0;
                    acc_next  = '0;
                    if (cmd.len_a == '0)
                    begin
                        kmax_next  = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        kmax_next  = K_W'(K_W'(cmd.len_a) + K_W'(cmd.len_b) - K_W'(2));
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                i_next = i_reg + IDX_W'(1);
                if (i_reg == iend_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (s2_valid_reg && s2_last_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_coeff_next = OUT_WIDTH'(acc_reg);
                    out_err_next   = err_reg;
                    out_last_next  = (k_reg == kmax_reg);
                    if (k_reg == kmax_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next    = k_inc;
                        acc_next  = '0;
                        i_next    = (k_inc >= lb_k) ? IDX_W'(k_inc - lb_k + K_W'(1)) : '0;
                        iend_next = (k_inc < la_k) ? IDX_W'(k_inc) : IDX_W'(la_k - K_W'(1));
                        state_next = ST_CALC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // coefficient stores and their registered read ports
    always_ff @(posedge clk)
    begin
        if (pop && cmd.wr && !cmd.is_b)
            mem_a[cmd.addr] <= cmd.coeff;
        if (pop && cmd.wr && cmd.is_b)
            mem_b[cmd.addr] <= cmd.coeff;
        rd_a_reg <= mem_a[i_reg];
        rd_b_reg <= mem_b[addr_b];
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= rd_a_reg * rd_b_reg;
        acc_reg        <= acc_next;
        la_reg         <= la_next;
        lb_reg         <= lb_next;
        err_reg        <= err_next;
        k_reg          <= k_next;
        kmax_reg       <= kmax_next;
        i_reg          <= i_next;
        iend_reg       <= iend_next;
        out_coeff_reg  <= out_coeff_next;
        out_err_reg    <= out_err_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= (state_reg == ST_CALC);
            s1_last_reg   <= (i_reg == iend_reg);
            s2_valid_reg  <= s1_valid_reg;
            s2_last_reg   <= s1_last_reg;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/polynomial_multiplier.sv =====
// Polynomial multiplier: takes two integer polynomials one coefficient word at a time,
// highest degree first (opcode 0 = first operand, opcode 1 = second operand), and on a
// second-operand word with last set streams out the full linear convolution,
// len_a + len_b - 1 coefficients, highest degree first, last_of_run on the final one.
// Results are full width and never wrap. Up to 32 coefficients per operand are kept;
// extra ones, and first-operand words after the first operand was closed, are dropped
// and set error on every result of the run. An empty first operand yields a single zero
// result with error set. Load words land in a two-entry command queue, so the front
// keeps taking words while a product is being computed, until the queue fills. The
// product is worked out by one 16x16 multiplier and accumulator fed from the two
// coefficient stores: each output coefficient sums its terms, one store read per term,
// through two pipeline stages, and is then handed to the result register.
// Output words wait in a result register; a stalled sink holds the engine.
module polynomial_multiplier (
    input  logic         clk,
    input  logic         rst_n,
    pm_operand_if.sink   operand,
    pm_product_if.source product
);
    import pm_pkg::*;

    cmd_t q_in;
    cmd_t q_out;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    // classify words and track operand counts
    pm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .cmd     (q_in),
        .push    (q_push),
        .full    (q_full)
    );

    // decouple loading from the multiply-accumulate run
    pm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .cmd_out (q_out),
        .empty   (q_empty)
    );

    // store coefficients and compute the convolution
    pm_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (q_out),
        .empty   (q_empty),
        .pop     (q_pop),
        .product (product)
    );

endmodule
